// ----- hw/rtl/cdq_pkg.sv -----
// shared types, constants and helpers for the circular deque
package cdq_pkg;

    localparam int SLOTS  = 256;
    localparam int PTR_W  = $clog2(SLOTS);
    localparam int DATA_W = 32;
    localparam int CAP_W  = 8;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;
    localparam int SIZE_W = PTR_W + 1;
    localparam int CALC_W = (CAP_W + 1 > SIZE_W) ? CAP_W + 1 : SIZE_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(255);

    // operation codes
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 2'd1;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [DATA_W-1:0] t_word;

    // one access to the ring memory
    typedef struct packed {
        logic  we;
        logic  re;
        t_ptr  addr;
        t_word wdata;
    } t_ring_req;

    // result of one transaction, minus the popped word
    typedef struct packed {
        logic              load;
        logic              pop_ok;
        logic [STAT_W-1:0] status;
        logic              now_full;
        logic              now_empty;
    } t_meta;

    // highest ring index: ring has max(cap,1)+1 slots, at most SLOTS
    function automatic t_ptr ring_last(input logic [CAP_W-1:0] cap);
        logic [CALC_W-1:0] m;
        m = (cap == '0) ? CALC_W'(2) : CALC_W'(cap) + CALC_W'(1);
        if (m > CALC_W'(SLOTS)) begin
            m = CALC_W'(SLOTS);
        end
        return PTR_W'(m - CALC_W'(1));
    endfunction

endpackage

// ----- hw/rtl/cdq_ring.sv -----
// ring storage: a single port with one shared address for writes and registered reads
module cdq_ring
    import cdq_pkg::*;
(
    input  logic      i_clk,
    input  t_ring_req i_req,
    output t_word     o_rd_data
);

    t_word r_mem [SLOTS];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/cdq_ctrl.sv -----
// pointer bookkeeping, capacity register and transaction sequencing
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [FUNC_W-1:0] i_func,
    input  t_word             i_value,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_data,
    input  logic              i_out_free,
    output t_ring_req         o_req,
    output t_meta             o_meta
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DATA = 1'b1;

    logic              r_state, n_state;
    t_ptr              r_front, n_front;
    t_ptr              r_back, n_back;
    t_ptr              r_last;
    logic              r_pop_ok, n_pop_ok;
    logic [STAT_W-1:0] r_status, n_status;
    logic              r_full, n_full;
    logic              r_empty, n_empty;

    logic accept;
    logic full, empty;
    t_ptr front_up, front_dn, back_up, back_dn;
    t_ptr back_up_n;

    assign accept = i_valid & (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);

    assign front_up = (r_front == r_last) ? '0 : r_front + PTR_W'(1);
    assign front_dn = (r_front == '0) ? r_last : r_front - PTR_W'(1);
    assign back_up  = (r_back == r_last) ? '0 : r_back + PTR_W'(1);
    assign back_dn  = (r_back == '0) ? r_last : r_back - PTR_W'(1);

    assign full  = (r_front == back_up);
    assign empty = (r_front == r_back);

    always_comb begin
        n_front  = r_front;
        n_back   = r_back;
        n_pop_ok = 1'b0;
        n_status = ST_OK;
        o_req    = '{we: 1'b0, re: 1'b0, addr: r_back, wdata: i_value};
        case (i_func)
            FN_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_back     = back_up;
                    o_req.we   = accept;
                    o_req.addr = back_up;
                end
            end
            FN_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_front    = front_dn;
                    o_req.we   = accept;
                    o_req.addr = r_front;
                end
            end
            FN_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_back     = back_dn;
                    n_pop_ok   = 1'b1;
                    o_req.re   = accept;
                    o_req.addr = r_back;
                end
            end
            default: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_front    = front_up;
                    n_pop_ok   = 1'b1;
                    o_req.re   = accept;
                    o_req.addr = front_up;
                end
            end
        endcase
        back_up_n = (n_back == r_last) ? '0 : n_back + PTR_W'(1);
        n_full    = (n_front == back_up_n);
        n_empty   = (n_front == n_back);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_back  <= '0;
            r_last  <= ring_last(CAP_RESET);
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_front <= '0;
                r_back  <= '0;
                r_last  <= ring_last(i_cfg_data);
            end else if (accept) begin
                r_front <= n_front;
                r_back  <= n_back;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pop_ok <= n_pop_ok;
            r_status <= n_status;
            r_full   <= n_full;
            r_empty  <= n_empty;
        end
    end

    assign o_meta = '{
        load:      (r_state == S_DATA) & i_out_free,
        pop_ok:    r_pop_ok,
        status:    r_status,
        now_full:  r_full,
        now_empty: r_empty
    };

endmodule

// ----- hw/rtl/circular_deque.sv -----
// top level of the circular deque: control, ring memory and output register
//
// double-ended queue of signed 32-bit words held in a 256-entry ring memory;
// the ring uses capacity+1 slots (capacity 0 acts as 1) and keeps one empty.
// each input transaction pushes or pops at either end (func: 0 push back,
// 1 push front, 2 pop back, 3 pop front) and yields exactly one result with
// the popped word (zero unless a pop succeeded), a status (0 ok, 1 full,
// 2 empty) and the full/empty flags after the operation. a rejected push or
// pop changes nothing. in an input transaction the pointers are updated and
// the memory is written or read at the accepting edge, and the registered
// read data of the ring memory lands in the output register once that
// register is free; o_stall stays high after each accept until that load.
// the output register lets a new transaction be accepted while the
// previous result still waits. writing capacity empties the queue and must
// only happen while the block is idle. no clearing pass after reset.
module circular_deque
    import cdq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic signed [DATA_W-1:0] i_value,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [CAP_W-1:0]         i_cfg_data,
    // result channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_data_out,
    output logic [STAT_W-1:0]        o_status,
    output logic                     o_now_full,
    output logic                     o_now_empty
);

    t_ring_req ring_req;
    t_meta     meta;
    t_word     rd_data;
    logic      out_free;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_data_out;
    logic [STAT_W-1:0]        r_status;
    logic                     r_now_full;
    logic                     r_now_empty;

    // output register can take a new result when empty or being drained
    assign out_free = ~r_out_valid | ~i_stall;

    cdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_func     (i_func),
        .i_value    (t_word'(i_value)),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_out_free (out_free),
        .o_req      (ring_req),
        .o_meta     (meta)
    );

    cdq_ring u_ring (
        .i_clk     (i_clk),
        .i_req     (ring_req),
        .o_rd_data (rd_data)
    );

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (meta.load) begin
            r_out_valid <= 1'b1;
        end else if (~i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, zero data unless a pop went through
    always_ff @(posedge i_clk) begin
        if (meta.load) begin
            r_data_out  <= meta.pop_ok ? $signed(rd_data) : '0;
            r_status    <= meta.status;
            r_now_full  <= meta.now_full;
            r_now_empty <= meta.now_empty;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_status    = r_status;
    assign o_now_full  = r_now_full;
    assign o_now_empty = r_now_empty;

endmodule

// ----- hw/rtl/cdq_checker.sv -----
// port-level checks for the circular deque and their binding
module cdq_checker
    import cdq_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_stall,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic signed [DATA_W-1:0] o_data_out,
    input logic [STAT_W-1:0]        o_status,
    input logic                     o_now_full,
    input logic                     o_now_empty
);

    // one transaction in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input accepted while previous transaction in flight");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data_out) && $stable(o_status))
        else $error("stalled result changed");

    // rejected operations return zero data
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_data_out == '0)
        else $error("rejected transaction returned data");

    // ring has at least two slots, so never full and empty together
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_now_full && o_now_empty))
        else $error("full and empty both set");

    // a push rejected as full leaves the queue full
    a_full_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_now_full)
        else $error("full rejection without full flag");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_data_out  (o_data_out),
    .o_status    (o_status),
    .o_now_full  (o_now_full),
    .o_now_empty (o_now_empty)
);
